// ----- src/h264fu_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// H.264 FU-A packetizer package
// Shared types and constants for the front, request queue and back end.
// ---------------------------------------------------------------------------
package h264fu_pkg;

	localparam logic [12:0] MAX_PAYLOAD_RST = 13'd1400;
	localparam logic [4:0]  FU_A_TYPE       = 5'd28;
	localparam int          QUEUE_DEPTH     = 4;
	localparam int          QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int          QCNT_W          = $clog2(QUEUE_DEPTH + 1);

	// one request from front to back: a plain byte or a fragment opening
	typedef struct packed {
		logic [7:0]  data;
		logic [7:0]  fu_ind;
		logic [7:0]  fu_hdr;
		logic        frag_open;
		logic        start;
		logic        pend;
		logic [15:0] seq;
	} fu_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- src/h264fu_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// H.264 FU-A packetizer front end
// Tracks position in the NAL unit, decides single vs FU-A, builds requests.
// ---------------------------------------------------------------------------
module h264fu_front import h264fu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	input  logic        in_fire,
	input  logic [7:0]  nal_byte,
	input  logic [15:0] nal_size,
	output logic        push,
	output fu_cmd_t     cmd
);

	logic [12:0] max_payload_q;
	logic [15:0] seq_q;
	logic [15:0] idx_q;
	logic [12:0] fill_q;
	logic [7:0]  hdr_q;
	logic        frag_q;

	logic [15:0] size;
	logic [12:0] maxp;
	logic        first;
	logic        last;
	logic        frag_now;
	logic [7:0]  hdr_now;
	logic [15:0] remain;
	logic        pend;
	logic [13:0] fill_inc;

	always_comb begin
		size     = (nal_size == 16'd0) ? 16'd1 : nal_size;
		maxp     = (max_payload_q == 13'd0) ? 13'd1 : max_payload_q;
		first    = (idx_q == 16'd0);
		last     = ({1'b0, idx_q} + 17'd1) >= {1'b0, size};
		frag_now = first ? (size > {3'd0, maxp}) : frag_q;
		hdr_now  = first ? nal_byte : hdr_q;
		remain   = (idx_q < size) ? (size - idx_q) : 16'd1;
		fill_inc = {1'b0, fill_q} + 14'd1;
		pend     = frag_now ? (last || (fill_inc >= {1'b0, maxp})) : last;
	end

	always_comb begin
		cmd.data      = nal_byte;
		cmd.fu_ind    = {hdr_now[7:5], FU_A_TYPE};
		cmd.fu_hdr    = {(idx_q == 16'd1), (remain <= {3'd0, maxp}), 1'b0, hdr_now[4:0]};
		cmd.frag_open = frag_now && (fill_q == 13'd0);
		cmd.start     = frag_now ? 1'b0 : first;
		cmd.pend      = pend;
		cmd.seq       = seq_q;
		// header byte of a fragmented unit is held, not sent
		push          = in_fire && !(frag_now && first);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
			seq_q         <= '0;
			idx_q         <= '0;
			fill_q        <= '0;
			hdr_q         <= '0;
			frag_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_payload_q <= cfg_wdata;
			end
			if (in_fire) begin
				hdr_q  <= hdr_now;
				frag_q <= frag_now;
				if (push && pend) begin
					seq_q <= seq_q + 16'd1;
				end
				if (frag_now && !first) begin
					fill_q <= pend ? 13'd0 : fill_inc[12:0];
				end
				if (last) begin
					idx_q  <= '0;
					frag_q <= 1'b0;
					fill_q <= '0;
				end else begin
					idx_q <= idx_q + 16'd1;
				end
			end
		end
	end

endmodule

// ----- src/h264fu_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// H.264 FU-A packetizer request queue
// Small FIFO that decouples the front end from the output expansion.
// ---------------------------------------------------------------------------
module h264fu_queue import h264fu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  fu_cmd_t push_cmd,
	input  logic    pop,
	output fu_cmd_t head,
	output q_stat_t stat
);

	fu_cmd_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign stat = '{full: (cnt_q == QCNT_W'(QUEUE_DEPTH)), empty: (cnt_q == '0)};
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- src/h264fu_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// H.264 FU-A packetizer back end
// Expands each request into one or three payload bytes into the output reg.
// ---------------------------------------------------------------------------
module h264fu_back import h264fu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  fu_cmd_t     head,
	input  q_stat_t     stat,
	output logic        pop,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [7:0]  payload_byte,
	output logic        packet_start,
	output logic        packet_end,
	output logic [15:0] seq_number,
	output logic        run_last
);

	logic [1:0]  phase_q;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic        start_q;
	logic        end_q;
	logic [15:0] seq_q;
	logic        rlast_q;

	logic        load;
	logic        last_phase;
	logic [7:0]  sel_byte;
	logic        sel_start;
	logic        sel_end;

	always_comb begin
		load       = !stat.empty && (!valid_q || out_ready);
		last_phase = !head.frag_open || (phase_q == 2'd2);
		pop        = load && last_phase;
		sel_byte   = head.data;
		sel_start  = head.start;
		sel_end    = head.pend;
		if (head.frag_open) begin
			case (phase_q)
				2'd0: begin
					sel_byte  = head.fu_ind;
					sel_start = 1'b1;
					sel_end   = 1'b0;
				end
				2'd1: begin
					sel_byte  = head.fu_hdr;
					sel_start = 1'b0;
					sel_end   = 1'b0;
				end
				default: begin
					sel_byte  = head.data;
					sel_start = 1'b0;
					sel_end   = head.pend;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= last_phase ? 2'd0 : phase_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= sel_byte;
			start_q <= sel_start;
			end_q   <= sel_end;
			seq_q   <= head.seq;
			rlast_q <= last_phase;
		end
	end

	assign out_valid    = valid_q;
	assign payload_byte = byte_q;
	assign packet_start = start_q;
	assign packet_end   = end_q;
	assign seq_number   = seq_q;
	assign run_last     = rlast_q;

endmodule

// ----- src/h264_rtp_fu_a_packetizer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// H.264 RTP packetizer, single-NAL and FU-A
// Accepts NAL bytes with unit size, emits RTP payload bytes with packet marks.
// ---------------------------------------------------------------------------
// Throughput: one input byte per cycle while the request queue is not full;
// one result per cycle on the output while m_tready is high. A byte that
// opens a fragment gives 3 results and occupies the back end for all 3 of
// them; a 4-entry request queue soaks up bursts, input stalls when it fills.
// Reset: asynchronous, clears sequence and unit state; max_payload resets to 1400.
module h264_rtp_fu_a_packetizer import h264fu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,     // max_payload
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,       // [7:0] nal_byte, [23:8] nal_size
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,       // [7:0] payload_byte, [23:8] seq_number
	output logic [1:0]  m_tuser,       // [0] packet_start, [1] run_last
	output logic        m_tlast        // packet_end
);

	logic    in_fire;
	logic    q_push;
	logic    q_pop;
	fu_cmd_t q_in;
	fu_cmd_t q_head;
	q_stat_t q_stat;

	logic [7:0]  payload_byte;
	logic        packet_start;
	logic        packet_end;
	logic [15:0] seq_number;
	logic        run_last;

	assign s_tready = !q_stat.full;
	assign in_fire  = s_tvalid && s_tready;

	h264fu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_fire   (in_fire),
		.nal_byte  (s_tdata[7:0]),
		.nal_size  (s_tdata[23:8]),
		.push      (q_push),
		.cmd       (q_in)
	);

	h264fu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	h264fu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.stat         (q_stat),
		.pop          (q_pop),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.payload_byte (payload_byte),
		.packet_start (packet_start),
		.packet_end   (packet_end),
		.seq_number   (seq_number),
		.run_last     (run_last)
	);

	assign m_tdata = {seq_number, payload_byte};
	assign m_tuser = {run_last, packet_start};
	assign m_tlast = packet_end;

`ifndef SYNTH
	// a packet always ends on the data byte, the final result of its input byte
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[1])
		else $error("packet_end without run_last");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	a_full_empty_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty at once");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the H.264 RTP FU-A packetizer
// Streams NAL bytes with unit sizes into the packetizer and checks every
// payload byte, packet mark, sequence number and request-end flag against
// a cycle-free model of single-NAL and FU-A packetization. A short table of
// directed cases comes first, then random units under changing max_payload
// settings, sender and receiver stalls, and one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb import h264fu_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_WAIT     = 8;
	localparam int HOLD_CYCLES    = 80;
	localparam int REPORT_MAX     = 10;

	typedef struct packed {
		logic [7:0]  pl;
		logic        sop;
		logic        eop;
		logic [15:0] seq;
		logic        rl;
	} fu_beat_t;

	typedef enum logic {ROW_NAL, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  b;
		logic [15:0] val;    // nal_size, or max_payload for a register write
		logic        typed;
		fu_beat_t    want;
	} stim_row_t;

	typedef struct packed {
		logic     typed;
		fu_beat_t want;
	} row_note_t;

	localparam int DIR_N = 25;
	localparam stim_row_t DIR_TAB [DIR_N] = '{
		// after reset, max_payload 1400: single-NAL packets
		'{ROW_NAL, 8'hFF, 16'd1,     1'b1, '{8'hFF, 1'b1, 1'b1, 16'd0, 1'b1}},
		'{ROW_NAL, 8'h00, 16'd0,     1'b1, '{8'h00, 1'b1, 1'b1, 16'd1, 1'b1}},
		'{ROW_NAL, 8'h65, 16'd2,     1'b1, '{8'h65, 1'b1, 1'b0, 16'd2, 1'b1}},
		'{ROW_NAL, 8'hAA, 16'd2,     1'b1, '{8'hAA, 1'b0, 1'b1, 16'd2, 1'b1}},
		// one over max, then the size drops so the unit ends at once
		'{ROW_NAL, 8'h41, 16'd1401,  1'b0, '0},
		'{ROW_NAL, 8'h5A, 16'd2,     1'b0, '0},
		// zero max_payload acts as one
		'{ROW_CFG, 8'h00, 16'd0,     1'b0, '0},
		'{ROW_NAL, 8'hE5, 16'd3,     1'b0, '0},
		'{ROW_NAL, 8'h11, 16'd3,     1'b0, '0},
		'{ROW_NAL, 8'h22, 16'd3,     1'b0, '0},
		// exactly max+1 bytes: one fragment with both S and E
		'{ROW_CFG, 8'h00, 16'd3,     1'b0, '0},
		'{ROW_NAL, 8'h7C, 16'd4,     1'b0, '0},
		'{ROW_NAL, 8'h01, 16'd4,     1'b0, '0},
		'{ROW_NAL, 8'h02, 16'd4,     1'b0, '0},
		'{ROW_NAL, 8'h03, 16'd4,     1'b0, '0},
		// max shrinks with a fragment open
		'{ROW_CFG, 8'h00, 16'd2,     1'b0, '0},
		'{ROW_NAL, 8'h9F, 16'd6,     1'b0, '0},
		'{ROW_NAL, 8'h10, 16'd6,     1'b0, '0},
		'{ROW_CFG, 8'h00, 16'd1,     1'b0, '0},
		'{ROW_NAL, 8'h20, 16'd6,     1'b0, '0},
		'{ROW_NAL, 8'h30, 16'd6,     1'b0, '0},
		'{ROW_NAL, 8'h40, 16'd6,     1'b0, '0},
		'{ROW_NAL, 8'h50, 16'd6,     1'b0, '0},
		// largest register value, largest size, cut to two bytes
		'{ROW_CFG, 8'h00, 16'd8191,  1'b0, '0},
		'{ROW_NAL, 8'h3C, 16'd65535, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [12:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;      // [7:0] nal_byte, [23:8] nal_size
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;           // [7:0] payload_byte, [23:8] seq_number
	logic [1:0]  m_tuser;           // [0] packet_start, [1] run_last
	logic        m_tlast;           // packet_end

	h264_rtp_fu_a_packetizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #10 clk = ~clk;

	// packetizer model state
	logic [12:0] mp_reg = MAX_PAYLOAD_RST;
	logic [15:0] seq_ctr = '0;
	logic [15:0] nal_pos = '0;
	logic [12:0] frag_fill = '0;
	logic [7:0]  hdr_byte = '0;
	logic        in_fu = 1'b0;
	fu_beat_t    pred_beats [3];
	int          pred_n;

	fu_beat_t    payload_q [$];
	row_note_t   row_note_q [$];
	row_note_t   note;
	fu_beat_t    got_beat;
	fu_beat_t    want_beat;
	int          err_cnt = 0;

	int src_idle = 0;
	int snk_idle = 0;
	bit hold_go = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;

	function automatic void packetize_byte(input logic [7:0] b, input logic [15:0] sz_in);
		int         sz;
		int         mp;
		int         idx;
		int         remain;
		logic       fin;
		logic       close;
		logic [7:0] fuh;
		sz = (sz_in == 0) ? 1 : int'(sz_in);
		mp = (mp_reg == 0) ? 1 : int'(mp_reg);
		idx = nal_pos;
		fin = (idx + 1 >= sz);
		pred_n = 0;
		if (idx == 0) begin
			in_fu = (sz > mp);
			hdr_byte = b;
		end
		if (!in_fu) begin
			pred_beats[0] = '{pl: b, sop: (idx == 0), eop: fin, seq: seq_ctr, rl: 1'b0};
			pred_n = 1;
			if (fin)
				seq_ctr = seq_ctr + 16'd1;
		end else if (idx != 0) begin
			if (frag_fill == 0) begin
				remain = (idx < sz) ? sz - idx : 1;
				// FU header: S, E, reserved zero, original type
				fuh = {(idx == 1), (remain <= mp), 1'b0, hdr_byte[4:0]};
				pred_beats[0] = '{pl: {hdr_byte[7:5], FU_A_TYPE}, sop: 1'b1, eop: 1'b0,
					seq: seq_ctr, rl: 1'b0};
				pred_beats[1] = '{pl: fuh, sop: 1'b0, eop: 1'b0, seq: seq_ctr, rl: 1'b0};
				pred_n = 2;
			end
			close = fin || (int'(frag_fill) + 1 >= mp);
			pred_beats[pred_n] = '{pl: b, sop: 1'b0, eop: close, seq: seq_ctr, rl: 1'b0};
			pred_n++;
			if (close) begin
				frag_fill = '0;
				seq_ctr = seq_ctr + 16'd1;
			end else begin
				frag_fill = frag_fill + 13'd1;
			end
		end
		if (fin) begin
			nal_pos = '0;
			in_fu = 1'b0;
			frag_fill = '0;
		end else begin
			nal_pos = 16'(idx + 1);
		end
		if (pred_n > 0)
			pred_beats[pred_n - 1].rl = 1'b1;
	endfunction

	// request monitor and result checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				packetize_byte(s_tdata[7:0], s_tdata[23:8]);
				note = row_note_q.pop_front();
				if (note.typed)
					payload_q.push_back(note.want);
				else
					for (int i = 0; i < pred_n; i++)
						payload_q.push_back(pred_beats[i]);
			end
			if (m_tvalid && m_tready) begin
				got_beat = '{pl: m_tdata[7:0], sop: m_tuser[0], eop: m_tlast,
					seq: m_tdata[23:8], rl: m_tuser[1]};
				if (payload_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= REPORT_MAX)
						$display("unexpected result: byte %h start %b end %b seq %0d last %b",
							got_beat.pl, got_beat.sop, got_beat.eop, got_beat.seq, got_beat.rl);
				end else begin
					want_beat = payload_q.pop_front();
					if (got_beat !== want_beat) begin
						err_cnt++;
						if (err_cnt <= REPORT_MAX) begin
							$write("mismatch: exp byte %h start %b end %b seq %0d last %b",
								want_beat.pl, want_beat.sop, want_beat.eop, want_beat.seq,
								want_beat.rl);
							$display(" | got byte %h start %b end %b seq %0d last %b",
								got_beat.pl, got_beat.sop, got_beat.eop,
								got_beat.seq, got_beat.rl);
						end
					end
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_go && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= snk_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[h264_rtp_fu_a_packetizer] ERROR");
			$finish;
		end
	end

	task automatic offer(input logic [7:0] b, input logic [15:0] sz, input logic typed,
			input fu_beat_t want);
		row_note_q.push_back('{typed: typed, want: want});
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {sz, b};
		do @(posedge clk); while (!s_tready);
	endtask

	// register write once everything has drained
	task automatic set_max(input logic [12:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (payload_q.size() != 0)
			@(posedge clk);
		// a fragmented header byte gives no result but may still be in flight
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		mp_reg = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_segment(input int src_pct, input int snk_pct, input logic [12:0] mpv,
			input int n_items, input bit with_hold);
		int sent;
		int pick;
		int sz;
		int k;
		int mpe;
		src_idle = src_pct;
		snk_idle = snk_pct;
		set_max(mpv);
		mpe = (mpv == 0) ? 1 : int'(mpv);
		sent = 0;
		while (sent < n_items) begin
			if (with_hold && sent >= 20)
				hold_go = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				// well-formed unit
				sz = $urandom_range(1, (mpe > 12) ? 40 : 3 * mpe + 3);
				for (k = 0; k < sz; k++)
					offer(8'($urandom_range(0, 255)), 16'(sz), 1'b0, '0);
				sent += sz;
			end else if (pick < 90) begin
				// huge declared size, then the size shrinks so the unit ends early
				sz = $urandom_range(16'h8000, 16'hFFFF);
				k = $urandom_range(1, 6);
				repeat (k) offer(8'($urandom_range(0, 255)), 16'(sz), 1'b0, '0);
				offer(8'($urandom_range(0, 255)), 16'(k + 1), 1'b0, '0);
				sent += k + 1;
			end else begin
				// noise sizes, closed by a size of zero or one
				k = $urandom_range(1, 4);
				repeat (k)
					offer(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 1'b0,
						'0);
				offer(8'($urandom_range(0, 255)), 16'($urandom_range(0, 1)), 1'b0, '0);
				sent += k + 1;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 13;
		snk_idle = 88;
		for (int i = 0; i < DIR_N; i++) begin
			if (DIR_TAB[i].kind == ROW_CFG)
				set_max(DIR_TAB[i].val[12:0]);
			else
				offer(DIR_TAB[i].b, DIR_TAB[i].val, DIR_TAB[i].typed, DIR_TAB[i].want);
		end
		// closes the 65535-byte unit opened by the last table row
		offer(8'hC3, 16'd2, 1'b0, '0);

		run_segment(13, 88, 13'd1, 30, 1'b0);
		run_segment(13, 88, 13'd4, 30, 1'b0);
		run_segment(88, 13, 13'd4096, 25, 1'b0);
		run_segment(88, 13, 13'($urandom_range(2, 12)), 30, 1'b0);
		run_segment(0, 0, 13'($urandom_range(2, 9)), 60, 1'b1);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (payload_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_cnt == 0 && payload_q.size() == 0)
			$display("[h264_rtp_fu_a_packetizer] OK");
		else
			$display("[h264_rtp_fu_a_packetizer] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
src/h264fu_pkg.sv
src/h264fu_front.sv
src/h264fu_queue.sv
src/h264fu_back.sv
src/h264_rtp_fu_a_packetizer.sv
tb/sv/tb.sv
